// File: hw/rtl/cli_pkg.sv
package cli_pkg;

  // Default coordinate width (signed fixed point, Q15.16 at 32 bits)
  localparam int CLI_COORD_WIDTH = 32;

  // Extra fraction bits kept inside the datapath
  localparam int CLI_GUARD = 8;

  // Configuration index width
  localparam int CLI_CFG_IDX_W = 2;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_HIT   = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_DEGEN = 2'd2
  } cli_status_t;

  // Configuration register indexes
  typedef enum logic [CLI_CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cli_reg_t;

endpackage

// File: hw/rtl/circle_line_intersection.sv
// Circle / line intersection. Each input item is a line through two points; the circle
// center and radius come from configuration registers (write them only while the block
// is idle). For each line one result item gives the two crossing points ordered by x,
// then y, with status 0 (crosses or touches), 1 (line misses the circle) or 2 (both
// points equal); on status 1 or 2 the coordinates are zero. The block takes one item
// per cycle while the pipeline is not held. The pipeline depth is set by the
// one-bit-per-stage square root and restoring divider pipelines. The whole pipeline
// holds while the result register is full and not taken and the last stage holds an
// item; bubbles are squeezed out otherwise.
module circle_line_intersection #(
  parameter int COORD_WIDTH = cli_pkg::CLI_COORD_WIDTH
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input line items
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // line_start_x, line_start_y, line_end_x, line_end_y (low to high), zero padded
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  // result items
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // first_x, first_y, second_x, second_y (low to high), zero padded
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]       out_tdata,
  // status
  output logic [1:0]                               out_tuser,
  // configuration writes
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [cli_pkg::CLI_CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-1:0]                   cfg_data
);
  import cli_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int G    = CLI_GUARD;
  localparam int DW   = CW + 1;          // differences
  localparam int PW   = 2 * DW;          // first products
  localparam int RADW = PW + 2 * G;      // length radicand
  localparam int NDW  = RADW / 2;        // scaled line length
  localparam int QW   = CW + G + 3;      // distance / projection quotient
  localparam int NUMW = PW + 2 * G;      // first dividend
  localparam int SW   = QW + 1;          // signed projection
  localparam int RGW  = CW - 1 + G;      // scaled radius
  localparam int R2W  = 2 * RGW;
  localparam int HW   = RGW;             // half chord
  localparam int DLW  = QW / 2;          // low split of the distance
  localparam int KW   = QW + 2;          // s +/- h
  localparam int KLW  = KW / 2;          // low split of k
  localparam int PLW  = DW + KLW + 1;    // low partial product
  localparam int PHW  = DW + KW - KLW;   // high partial product
  localparam int PRW  = DW + KW;         // second products
  localparam int N2W  = PRW + 1;         // rounding dividend
  localparam int OW   = CW + 4;          // offset quotient
  localparam int VW   = OW + 2;          // point before saturation
  localparam int BUSW = ((4 * CW + 7) / 8) * 8;
  localparam int LAT  = 3 + NDW + QW + 2 + HW + 4 + OW + 2;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 degen;
  } geo_t;

  typedef struct packed {
    geo_t          g;
    logic [PW-1:0] acrs;
    logic [PW-1:0] adt;
    logic          dtneg;
  } sq1_side_t;

  typedef struct packed {
    geo_t           g;
    logic [NDW-1:0] nd;
    logic           dtneg;
  } dv1_side_t;

  typedef struct packed {
    geo_t                 g;
    logic [NDW-1:0]       nd;
    logic signed [SW-1:0] s;
    logic                 miss;
  } mid_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic [NDW:0]         nd2;
    logic [3:0]           neg;
    logic                 degen;
    logic                 miss;
  } dv2_side_t;

  // ---------------------------------------------------------------- configuration
  logic signed [CW-1:0] ctr_x_r, ctr_y_r;
  logic [CW-2:0]        rad_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_x_r <= '0;
      ctr_y_r <= '0;
      rad_r   <= '0;
    end else if (cfg_valid) begin
      case (cli_reg_t'(cfg_index))
        REG_CENTER_X: ctr_x_r <= cfg_data;
        REG_CENTER_Y: ctr_y_r <= cfg_data;
        REG_RADIUS:   rad_r   <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [LAT-1:0] vld_r;
  logic           adv;
  logic           out_tvalid_r;

  assign adv       = !vld_r[LAT-1] || !out_tvalid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- S1: differences
  logic signed [CW-1:0] in_x1, in_y1, in_x2, in_y2;
  geo_t                 s1_g_r;
  logic signed [DW-1:0] s1_wx_r, s1_wy_r;
  logic signed [DW-1:0] s1_dx, s1_dy;

  assign in_x1 = in_tdata[0*CW +: CW];
  assign in_y1 = in_tdata[1*CW +: CW];
  assign in_x2 = in_tdata[2*CW +: CW];
  assign in_y2 = in_tdata[3*CW +: CW];
  assign s1_dx = DW'(in_x2) - DW'(in_x1);
  assign s1_dy = DW'(in_y2) - DW'(in_y1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_g_r.x1    <= in_x1;
      s1_g_r.y1    <= in_y1;
      s1_g_r.dx    <= s1_dx;
      s1_g_r.dy    <= s1_dy;
      s1_g_r.degen <= (s1_dx == '0) && (s1_dy == '0);
      s1_wx_r      <= DW'(ctr_x_r) - DW'(in_x1);
      s1_wy_r      <= DW'(ctr_y_r) - DW'(in_y1);
    end
  end

  // ---------------------------------------------------------------- S2: products
  geo_t                 s2_g_r;
  logic signed [PW-1:0] s2_xx_r, s2_yy_r, s2_xwy_r, s2_ywx_r, s2_xwx_r, s2_ywy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_g_r   <= s1_g_r;
      s2_xx_r  <= PW'(s1_g_r.dx) * PW'(s1_g_r.dx);
      s2_yy_r  <= PW'(s1_g_r.dy) * PW'(s1_g_r.dy);
      s2_xwy_r <= PW'(s1_g_r.dx) * PW'(s1_wy_r);
      s2_ywx_r <= PW'(s1_g_r.dy) * PW'(s1_wx_r);
      s2_xwx_r <= PW'(s1_g_r.dx) * PW'(s1_wx_r);
      s2_ywy_r <= PW'(s1_g_r.dy) * PW'(s1_wy_r);
    end
  end

  // ---------------------------------------------------------------- S3: length^2, cross, dot
  logic signed [PW:0] s3_crs, s3_dt;
  logic [PW-1:0]      s3_l2_r;
  sq1_side_t          s3_sd_r;

  assign s3_crs = (PW+1)'(s2_xwy_r) - (PW+1)'(s2_ywx_r);
  assign s3_dt  = (PW+1)'(s2_xwx_r) + (PW+1)'(s2_ywy_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_l2_r       <= s2_xx_r + s2_yy_r;
      s3_sd_r.g     <= s2_g_r;
      s3_sd_r.acrs  <= s3_crs[PW] ? PW'(-s3_crs) : s3_crs[PW-1:0];
      s3_sd_r.adt   <= s3_dt[PW] ? PW'(-s3_dt) : s3_dt[PW-1:0];
      s3_sd_r.dtneg <= s3_dt[PW];
    end
  end

  // ---------------------------------------------------------------- square root: line length
  logic [RADW-1:0] sq1_rad_r  [1:NDW];
  logic [NDW:0]    sq1_rem_r  [1:NDW];
  logic [NDW-1:0]  sq1_root_r [1:NDW];
  sq1_side_t       sq1_sd_r   [1:NDW];

  for (genvar k = 0; k < NDW; k++) begin : g_sq1
    logic [RADW-1:0] rad_i;
    logic [NDW:0]    rem_i;
    logic [NDW-1:0]  root_i;
    sq1_side_t       sd_i;
    logic [NDW+2:0]  rsh, trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_i  = {s3_l2_r, {(2*G){1'b0}}};
      assign rem_i  = '0;
      assign root_i = '0;
      assign sd_i   = s3_sd_r;
    end else begin : g_next
      assign rad_i  = sq1_rad_r[k];
      assign rem_i  = sq1_rem_r[k];
      assign root_i = sq1_root_r[k];
      assign sd_i   = sq1_sd_r[k];
    end

    // one root bit per stage
    assign rsh   = {rem_i, rad_i[RADW-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_rad_r[k+1]  <= rad_i << 2;
        sq1_rem_r[k+1]  <= ge ? (NDW+1)'(rsh - trial) : rsh[NDW:0];
        sq1_root_r[k+1] <= {root_i[NDW-2:0], ge};
        sq1_sd_r[k+1]   <= sd_i;
      end
    end
  end

  // ---------------------------------------------------------------- divide: distance and projection
  logic [1:0][NDW-1:0] dv1_rem_r [1:QW];
  logic [1:0][QW-1:0]  dv1_qn_r  [1:QW];
  dv1_side_t           dv1_sd_r  [1:QW];

  logic [NUMW-1:0] dv1_num_c, dv1_num_t;
  assign dv1_num_c = {sq1_sd_r[NDW].acrs, {(2*G){1'b0}}};
  assign dv1_num_t = {sq1_sd_r[NDW].adt, {(2*G){1'b0}}};

  for (genvar k = 0; k < QW; k++) begin : g_dv1
    logic [1:0][NDW-1:0] rem_i, rem_o;
    logic [1:0][QW-1:0]  qn_i, qn_o;
    dv1_side_t           sd_i;
    logic [NDW:0]        rsh;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_i[0] = NDW'(dv1_num_c[NUMW-1:QW]);
      assign rem_i[1] = NDW'(dv1_num_t[NUMW-1:QW]);
      assign qn_i[0]  = dv1_num_c[QW-1:0];
      assign qn_i[1]  = dv1_num_t[QW-1:0];
      assign sd_i.g     = sq1_sd_r[NDW].g;
      assign sd_i.nd    = sq1_root_r[NDW];
      assign sd_i.dtneg = sq1_sd_r[NDW].dtneg;
    end else begin : g_next
      assign rem_i = dv1_rem_r[k];
      assign qn_i  = dv1_qn_r[k];
      assign sd_i  = dv1_sd_r[k];
    end

    // one quotient bit per stage in each lane
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rsh      = {rem_i[l], qn_i[l][QW-1]};
        ge       = rsh >= {1'b0, sd_i.nd};
        rem_o[l] = ge ? NDW'(rsh - {1'b0, sd_i.nd}) : rsh[NDW-1:0];
        qn_o[l]  = {qn_i[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv1_rem_r[k+1] <= rem_o;
        dv1_qn_r[k+1]  <= qn_o;
        dv1_sd_r[k+1]  <= sd_i;
      end
    end
  end

  // ---------------------------------------------------------------- S4: signed s, miss test, partial squares
  logic [QW-1:0]       s4_dist, s4_sq;
  logic [RGW-1:0]      s4_rg;
  logic [QW+DLW-1:0]   s4_dlo_r;
  logic [2*QW-DLW-1:0] s4_dhi_r;
  logic [R2W-1:0]      s4_r2_r;
  mid_t                s4_m_r;

  assign s4_dist = dv1_qn_r[QW][0];
  assign s4_sq   = dv1_qn_r[QW][1];
  assign s4_rg   = {rad_r, {G{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      // distance squared split on the low DLW bits of one factor
      s4_dlo_r    <= (QW+DLW)'(s4_dist) * (QW+DLW)'(s4_dist[DLW-1:0]);
      s4_dhi_r    <= (2*QW-DLW)'(s4_dist) * (2*QW-DLW)'(s4_dist[QW-1:DLW]);
      s4_r2_r     <= {(2*(CW-1))'(rad_r) * (2*(CW-1))'(rad_r), {(2*G){1'b0}}};
      s4_m_r.g    <= dv1_sd_r[QW].g;
      s4_m_r.nd   <= dv1_sd_r[QW].nd;
      s4_m_r.s    <= dv1_sd_r[QW].dtneg ? -$signed({1'b0, s4_sq}) : $signed({1'b0, s4_sq});
      // both nonnegative: dist^2 > r^2 exactly when dist > r
      s4_m_r.miss <= s4_dist > QW'(s4_rg);
    end
  end

  // ---------------------------------------------------------------- S5: r^2 - d^2
  logic [R2W-1:0] s5_diff_r;
  mid_t           s5_m_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_diff_r <= s4_r2_r - R2W'(s4_dlo_r) - R2W'({s4_dhi_r, {DLW{1'b0}}});
      s5_m_r    <= s4_m_r;
    end
  end

  // ---------------------------------------------------------------- square root: half chord
  logic [R2W-1:0] sq2_rad_r  [1:HW];
  logic [HW:0]    sq2_rem_r  [1:HW];
  logic [HW-1:0]  sq2_root_r [1:HW];
  mid_t           sq2_m_r    [1:HW];

  for (genvar k = 0; k < HW; k++) begin : g_sq2
    logic [R2W-1:0] rad_i;
    logic [HW:0]    rem_i;
    logic [HW-1:0]  root_i;
    mid_t           m_i;
    logic [HW+2:0]  rsh, trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_i  = s5_diff_r;
      assign rem_i  = '0;
      assign root_i = '0;
      assign m_i    = s5_m_r;
    end else begin : g_next
      assign rad_i  = sq2_rad_r[k];
      assign rem_i  = sq2_rem_r[k];
      assign root_i = sq2_root_r[k];
      assign m_i    = sq2_m_r[k];
    end

    assign rsh   = {rem_i, rad_i[R2W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_rad_r[k+1]  <= rad_i << 2;
        sq2_rem_r[k+1]  <= ge ? (HW+1)'(rsh - trial) : rsh[HW:0];
        sq2_root_r[k+1] <= {root_i[HW-2:0], ge};
        sq2_m_r[k+1]    <= m_i;
      end
    end
  end

  // ---------------------------------------------------------------- S6: s + h, s - h
  logic signed [KW-1:0] s6_kp_r, s6_km_r, s6_s, s6_h;
  mid_t                 s6_m_r;

  assign s6_s = KW'(sq2_m_r[HW].s);
  assign s6_h = $signed(KW'(sq2_root_r[HW]));

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_kp_r <= s6_s + s6_h;
      s6_km_r <= s6_s - s6_h;
      s6_m_r  <= sq2_m_r[HW];
    end
  end

  // ---------------------------------------------------------------- S7a: direction times k, partial products
  // lanes: 0 = a.x, 1 = a.y, 2 = b.x, 3 = b.y
  logic signed [DW-1:0]  s7_dc   [4];
  logic signed [KW-1:0]  s7_k    [4];
  logic signed [PLW-1:0] s7_lo_r [4];
  logic signed [PHW-1:0] s7_hi_r [4];
  mid_t                  s7_pm_r;

  assign s7_dc[0] = s6_m_r.g.dx;
  assign s7_dc[1] = s6_m_r.g.dy;
  assign s7_dc[2] = s6_m_r.g.dx;
  assign s7_dc[3] = s6_m_r.g.dy;
  assign s7_k[0]  = s6_kp_r;
  assign s7_k[1]  = s6_kp_r;
  assign s7_k[2]  = s6_km_r;
  assign s7_k[3]  = s6_km_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s7_lo_r[l] <= PLW'(s7_dc[l]) * PLW'($signed({1'b0, s7_k[l][KLW-1:0]}));
        s7_hi_r[l] <= PHW'(s7_dc[l]) * PHW'($signed(s7_k[l][KW-1:KLW]));
      end
      s7_pm_r <= s6_m_r;
    end
  end

  // ---------------------------------------------------------------- S7b: sum partial products
  logic signed [3:0][PRW-1:0] s7_p_r;
  mid_t                       s7_m_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s7_p_r[l] <= (PRW'(s7_hi_r[l]) <<< KLW) + PRW'(s7_lo_r[l]);
      end
      s7_m_r <= s7_pm_r;
    end
  end

  // ---------------------------------------------------------------- S8: rounding dividends
  logic [3:0][N2W-1:0] s8_num_r;
  logic [3:0][PRW-1:0] s8_abs;
  dv2_side_t           s8_sd_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      s8_abs[l] = s7_p_r[l][PRW-1] ? PRW'(-s7_p_r[l]) : s7_p_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s8_num_r[l]   <= {s8_abs[l], 1'b0} + N2W'(s7_m_r.nd);
        s8_sd_r.neg[l] <= s7_p_r[l][PRW-1];
      end
      s8_sd_r.x1    <= s7_m_r.g.x1;
      s8_sd_r.y1    <= s7_m_r.g.y1;
      s8_sd_r.nd2   <= {s7_m_r.nd, 1'b0};
      s8_sd_r.degen <= s7_m_r.g.degen;
      s8_sd_r.miss  <= s7_m_r.miss;
    end
  end

  // ---------------------------------------------------------------- divide: offsets, four lanes
  logic [3:0][NDW:0]  dv2_rem_r [1:OW];
  logic [3:0][OW-1:0] dv2_qn_r  [1:OW];
  dv2_side_t          dv2_sd_r  [1:OW];

  for (genvar k = 0; k < OW; k++) begin : g_dv2
    logic [3:0][NDW:0]  rem_i, rem_o;
    logic [3:0][OW-1:0] qn_i, qn_o;
    dv2_side_t          sd_i;
    logic [NDW+1:0]     rsh;
    logic               ge;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_i[l] = s8_num_r[l][OW +: NDW+1];
        assign qn_i[l]  = s8_num_r[l][OW-1:0];
      end
      assign sd_i = s8_sd_r;
    end else begin : g_next
      assign rem_i = dv2_rem_r[k];
      assign qn_i  = dv2_qn_r[k];
      assign sd_i  = dv2_sd_r[k];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        rsh      = {rem_i[l], qn_i[l][OW-1]};
        ge       = rsh >= {1'b0, sd_i.nd2};
        rem_o[l] = ge ? (NDW+1)'(rsh - {1'b0, sd_i.nd2}) : rsh[NDW:0];
        qn_o[l]  = {qn_i[l][OW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv2_rem_r[k+1] <= rem_o;
        dv2_qn_r[k+1]  <= qn_o;
        dv2_sd_r[k+1]  <= sd_i;
      end
    end
  end

  // ---------------------------------------------------------------- S9: add base, saturate
  logic signed [3:0][CW-1:0] s9_pt_r;
  logic                      s9_degen_r, s9_miss_r;
  logic signed [VW-1:0]      s9_off, s9_base, s9_sum;
  logic signed [3:0][CW-1:0] s9_sat;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      s9_base = (l % 2 == 0) ? VW'(dv2_sd_r[OW].x1) : VW'(dv2_sd_r[OW].y1);
      s9_off  = $signed(VW'(dv2_qn_r[OW][l]));
      s9_sum  = s9_base + (dv2_sd_r[OW].neg[l] ? -s9_off : s9_off);
      if (s9_sum[VW-1:CW-1] == '0 || s9_sum[VW-1:CW-1] == '1) begin
        s9_sat[l] = s9_sum[CW-1:0];
      end else if (s9_sum[VW-1]) begin
        s9_sat[l] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        s9_sat[l] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_pt_r    <= s9_sat;
      s9_degen_r <= dv2_sd_r[OW].degen;
      s9_miss_r  <= dv2_sd_r[OW].miss;
    end
  end

  // ---------------------------------------------------------------- S10: order, status
  logic signed [3:0][CW-1:0] s10_pt_r;
  cli_status_t               s10_stat_r;
  logic                      s10_a_first;

  // element selects of a packed array are unsigned: compare as signed coordinates
  assign s10_a_first = ($signed(s9_pt_r[0]) < $signed(s9_pt_r[2])) ||
                       ((s9_pt_r[0] == s9_pt_r[2]) &&
                        ($signed(s9_pt_r[1]) <= $signed(s9_pt_r[3])));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s9_degen_r) begin
        s10_pt_r   <= '0;
        s10_stat_r <= STAT_DEGEN;
      end else if (s9_miss_r) begin
        s10_pt_r   <= '0;
        s10_stat_r <= STAT_MISS;
      end else if (s10_a_first) begin
        s10_pt_r   <= s9_pt_r;
        s10_stat_r <= STAT_HIT;
      end else begin
        s10_pt_r   <= {s9_pt_r[1], s9_pt_r[0], s9_pt_r[3], s9_pt_r[2]};
        s10_stat_r <= STAT_HIT;
      end
    end
  end

  // ---------------------------------------------------------------- result register
  logic [BUSW-1:0] out_tdata_r;
  logic [1:0]      out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_tready || !out_tvalid_r) begin
      out_tvalid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_tvalid_r) begin
      out_tdata_r <= BUSW'(s10_pt_r);
      out_tuser_r <= s10_stat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
